[hw/rtl/bde_pkg.sv]
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and codes of the bounded deque engine: command kinds, result
// status codes, controller states and the result transaction layout.
// ----------------------------------------------------------------------------
package bde_pkg;

   localparam int DATA_W   = 32;
   localparam int KIND_W   = 4;
   localparam int STATUS_W = 2;

   // command kinds carried on the request channel
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD_FRONT   = 4'd0,
      KIND_ADD_BACK    = 4'd1,
      KIND_DEL_FRONT   = 4'd2,
      KIND_DEL_BACK    = 4'd3,
      KIND_CLEAR       = 4'd4,
      KIND_DEL_VALUE   = 4'd5,
      KIND_PRINT_ALL   = 4'd6,
      KIND_PRINT_FIRST = 4'd7,
      KIND_PRINT_LAST  = 4'd8
   } kind_type;

   // status codes carried on the response channel
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DATA  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_NONE  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_PRINT,
      S_STATUS
   } state_type;

   // one result transaction
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic                     last;
   } rsp_item_type;

endpackage

[hw/rtl/bde_req_if.sv]
// ----------------------------------------------------------------------------
// bde_req_if
// Command channel of the deque engine: valid/ready handshake with the
// command kind and its operand.
// ----------------------------------------------------------------------------
interface bde_req_if;
   logic                               valid;
   logic                               ready;
   logic [bde_pkg::KIND_W-1:0]         kind;
   logic signed [bde_pkg::DATA_W-1:0]  operand;

   modport source (output valid, output kind, output operand, input ready);
   modport sink   (input valid, input kind, input operand, output ready);
endinterface

[hw/rtl/bde_rsp_if.sv]
// ----------------------------------------------------------------------------
// bde_rsp_if
// Result channel of the deque engine: valid/ready handshake with the printed
// value, a status code and the last-of-command flag.
// ----------------------------------------------------------------------------
interface bde_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bde_pkg::DATA_W-1:0]  value;
   logic [bde_pkg::STATUS_W-1:0]       status;
   logic                               last;

   modport source (output valid, output value, output status, output last, input ready);
   modport sink   (input valid, input value, input status, input last, output ready);
endinterface

[hw/rtl/bde_store.sv]
// ----------------------------------------------------------------------------
// bde_store
// Ring storage of the deque: one write port, one read port with a registered
// read data output. Read data holds between reads.
// ----------------------------------------------------------------------------
module bde_store #(
   parameter int DEPTH = 64,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [bde_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [bde_pkg::DATA_W-1:0] rd_data
);

   logic [bde_pkg::DATA_W-1:0] store_mem [DEPTH];
   logic [bde_pkg::DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read port, hold data when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bde_out.sv]
// ----------------------------------------------------------------------------
// bde_out
// Output register of the result channel. Takes one result transaction from
// the controller whenever it is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module bde_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  bde_pkg::rsp_item_type push_item,
   output logic                  push_ok,
   bde_rsp_if.source             rsp_chan
);

   logic                  valid_ff;
   logic                  valid_in;
   bde_pkg::rsp_item_type item_ff;
   bde_pkg::rsp_item_type item_in;

   assign push_ok = !valid_ff || rsp_chan.ready;

   // load on push, drop when taken
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push_valid && push_ok) begin
         valid_in = 1'b1;
         item_in  = push_item;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_chan.valid  = valid_ff;
   assign rsp_chan.value  = item_ff.value;
   assign rsp_chan.status = item_ff.status;
   assign rsp_chan.last   = item_ff.last;

endmodule

[hw/rtl/bde_ctrl.sv]
// ----------------------------------------------------------------------------
// bde_ctrl
// Command sequencer of the deque engine. Holds head index and entry count,
// drives the ring storage and walks it for prints and delete-by-value.
// ----------------------------------------------------------------------------
module bde_ctrl #(
   parameter int DEPTH = 64,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   // command transaction
   input  logic                              req_valid,
   input  logic [bde_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [bde_pkg::DATA_W-1:0] req_operand,
   output logic                              req_ready,
   // ring storage
   output logic                              mem_wr_en,
   output logic [IDX_W-1:0]                  mem_wr_addr,
   output logic [bde_pkg::DATA_W-1:0]        mem_wr_data,
   output logic                              mem_rd_en,
   output logic [IDX_W-1:0]                  mem_rd_addr,
   input  logic [bde_pkg::DATA_W-1:0]        mem_rd_data,
   // result transaction
   output logic                              push_valid,
   output bde_pkg::rsp_item_type             push_item,
   input  logic                              push_ok
);

   bde_pkg::state_type                 state_ff, state_in;
   logic [bde_pkg::KIND_W-1:0]         kind_ff, kind_in;
   logic signed [bde_pkg::DATA_W-1:0]  operand_ff, operand_in;
   logic [IDX_W-1:0]                   head_ff, head_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   rd_off_ff, rd_off_in;
   logic [CNT_W-1:0]                   wr_off_ff, wr_off_in;
   logic [CNT_W-1:0]                   left_ff, left_in;
   bde_pkg::status_type                status_ff, status_in;

   logic             full;
   logic             empty;
   logic             is_add;
   logic             is_front_add;
   logic             is_del_value;
   logic             is_print;
   logic             count_ok;
   logic             clip;
   logic [CNT_W-1:0] n_sel;
   logic [CNT_W-1:0] first_sel;
   logic [IDX_W-1:0] head_dec;
   logic [IDX_W-1:0] head_inc;
   logic [CNT_W-1:0] rd_off_sel;
   logic [CNT_W-1:0] wr_off_sel;
   logic             scan_more;
   logic             keep;

   // ring slot of an offset from the head
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // command decode on the held transaction
   assign full         = (count_ff == CNT_W'(DEPTH));
   assign empty        = (count_ff == '0);
   assign is_add       = (kind_ff == bde_pkg::KIND_ADD_FRONT) ||
                         (kind_ff == bde_pkg::KIND_ADD_BACK);
   assign is_front_add = (kind_ff == bde_pkg::KIND_ADD_FRONT);
   assign is_del_value = (kind_ff == bde_pkg::KIND_DEL_VALUE);
   assign is_print     = (kind_ff == bde_pkg::KIND_PRINT_ALL) ||
                         (kind_ff == bde_pkg::KIND_PRINT_FIRST) ||
                         (kind_ff == bde_pkg::KIND_PRINT_LAST);
   assign count_ok     = (kind_ff == bde_pkg::KIND_PRINT_ALL) ||
                         (!operand_ff[bde_pkg::DATA_W-1] && (operand_ff != '0));
   assign clip         = ($unsigned(operand_ff) > bde_pkg::DATA_W'(count_ff));
   assign n_sel        = ((kind_ff == bde_pkg::KIND_PRINT_ALL) || clip) ?
                         count_ff : operand_ff[CNT_W-1:0];
   assign first_sel    = (kind_ff == bde_pkg::KIND_PRINT_LAST) ? count_ff - n_sel : '0;
   assign head_dec     = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc     = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign scan_more    = (rd_off_ff < count_ff);
   assign keep         = (mem_rd_data != operand_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bde_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bde_pkg::S_EXEC;
            end
         end
         bde_pkg::S_EXEC: begin
            state_in = bde_pkg::S_IDLE;
            if (is_add && full) begin
               state_in = bde_pkg::S_STATUS;
            end else if (is_del_value && !empty) begin
               state_in = bde_pkg::S_SCAN;
            end else if (is_print) begin
               state_in = (empty || !count_ok) ? bde_pkg::S_STATUS : bde_pkg::S_PRINT;
            end
         end
         bde_pkg::S_SCAN: begin
            if (!scan_more) begin
               state_in = bde_pkg::S_IDLE;
            end
         end
         bde_pkg::S_PRINT: begin
            if (push_ok && (left_ff == CNT_W'(1))) begin
               state_in = bde_pkg::S_IDLE;
            end
         end
         bde_pkg::S_STATUS: begin
            if (push_ok) begin
               state_in = bde_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bde_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in     = kind_ff;
      operand_in  = operand_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      rd_off_in   = rd_off_ff;
      wr_off_in   = wr_off_ff;
      left_in     = left_ff;
      status_in   = status_ff;
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      rd_off_sel  = rd_off_ff;
      mem_wr_en   = 1'b0;
      wr_off_sel  = wr_off_ff;
      mem_wr_data = operand_ff;
      push_valid  = 1'b0;
      push_item   = '{value: '0, status: status_ff, last: 1'b1};

      case (state_ff)
         bde_pkg::S_IDLE: begin
            // take a command transaction
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = req_kind;
               operand_in = req_operand;
            end
         end
         bde_pkg::S_EXEC: begin
            case (bde_pkg::kind_type'(kind_ff))
               bde_pkg::KIND_ADD_FRONT, bde_pkg::KIND_ADD_BACK: begin
                  if (full) begin
                     status_in = bde_pkg::STATUS_FULL;
                  end else begin
                     mem_wr_en  = 1'b1;
                     wr_off_sel = count_ff;
                     count_in   = count_ff + 1'b1;
                     if (is_front_add) begin
                        head_in = head_dec;
                     end
                  end
               end
               bde_pkg::KIND_DEL_FRONT: begin
                  if (!empty) begin
                     head_in  = head_inc;
                     count_in = count_ff - 1'b1;
                  end
               end
               bde_pkg::KIND_DEL_BACK: begin
                  if (!empty) begin
                     count_in = count_ff - 1'b1;
                  end
               end
               bde_pkg::KIND_CLEAR: begin
                  head_in  = '0;
                  count_in = '0;
               end
               bde_pkg::KIND_DEL_VALUE: begin
                  // start the scan at the front
                  if (!empty) begin
                     mem_rd_en  = 1'b1;
                     rd_off_sel = '0;
                     rd_off_in  = CNT_W'(1);
                     wr_off_in  = '0;
                  end
               end
               bde_pkg::KIND_PRINT_ALL, bde_pkg::KIND_PRINT_FIRST,
               bde_pkg::KIND_PRINT_LAST: begin
                  if (empty) begin
                     status_in = bde_pkg::STATUS_EMPTY;
                  end else if (!count_ok) begin
                     status_in = bde_pkg::STATUS_NONE;
                  end else begin
                     mem_rd_en  = 1'b1;
                     rd_off_sel = first_sel;
                     rd_off_in  = first_sel + 1'b1;
                     left_in    = n_sel;
                  end
               end
               default: begin
               end
            endcase
         end
         bde_pkg::S_SCAN: begin
            // pack survivors toward the front
            mem_wr_data = mem_rd_data;
            if (keep) begin
               mem_wr_en = 1'b1;
               wr_off_in = wr_off_ff + 1'b1;
            end
            if (scan_more) begin
               mem_rd_en = 1'b1;
               rd_off_in = rd_off_ff + 1'b1;
            end else begin
               count_in = keep ? wr_off_ff + 1'b1 : wr_off_ff;
            end
         end
         bde_pkg::S_PRINT: begin
            // emit one entry, fetch the next
            push_item = '{value: mem_rd_data, status: bde_pkg::STATUS_DATA,
                          last: (left_ff == CNT_W'(1))};
            if (push_ok) begin
               push_valid = 1'b1;
               if (left_ff != CNT_W'(1)) begin
                  mem_rd_en = 1'b1;
                  rd_off_in = rd_off_ff + 1'b1;
                  left_in   = left_ff - 1'b1;
               end
            end
         end
         bde_pkg::S_STATUS: begin
            push_valid = push_ok;
         end
         default: begin
         end
      endcase
   end

   assign mem_rd_addr = slot_of(head_ff, rd_off_sel);
   assign mem_wr_addr = (state_ff == bde_pkg::S_EXEC && is_front_add) ?
                        head_dec : slot_of(head_ff, wr_off_sel);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bde_pkg::S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // command and walk registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      operand_ff <= operand_in;
      rd_off_ff  <= rd_off_in;
      wr_off_ff  <= wr_off_in;
      left_ff    <= left_in;
      status_ff  <= status_in;
   end

endmodule

[hw/rtl/bounded_deque_engine.sv]
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit values in a ring of DEPTH
// entries, with end adds and deletes, clear, delete-by-value and prints.
// ----------------------------------------------------------------------------
// One command is taken at a time. Adds that fit, end deletes, clear and
// unknown kinds finish in the execute state. Delete-by-value walks the ring
// through the single read port of the storage, one entry per cycle, writing
// survivors back toward the front. Prints read one entry per cycle while
// the result channel takes them. Status results (add when full, print when
// empty, nothing selected) go out from a status state. Any result also
// waits while the result channel stalls. A result waits in an output
// register, so the last result of a command may still be pending while the
// next command is taken.
module bounded_deque_engine #(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   bde_req_if.sink    req_chan,
   bde_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                        mem_wr_en;
   logic [IDX_W-1:0]            mem_wr_addr;
   logic [bde_pkg::DATA_W-1:0]  mem_wr_data;
   logic                        mem_rd_en;
   logic [IDX_W-1:0]            mem_rd_addr;
   logic [bde_pkg::DATA_W-1:0]  mem_rd_data;
   logic                        push_valid;
   bde_pkg::rsp_item_type       push_item;
   logic                        push_ok;

   // command sequencer
   bde_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_kind    (req_chan.kind),
      .req_operand (req_chan.operand),
      .req_ready   (req_chan.ready),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .push_valid  (push_valid),
      .push_item   (push_item),
      .push_ok     (push_ok)
   );

   // ring storage
   bde_store #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result register
   bde_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ok    (push_ok),
      .rsp_chan   (rsp_chan)
   );

endmodule
